### hdl/video_mosaic_window_layout_assert.svh
// assertion macros for the mosaic window layout block
// no dependencies; included by video_mosaic_window_layout, which checks itself
`ifndef VIDEO_MOSAIC_WINDOW_LAYOUT_ASSERT_SVH
`define VIDEO_MOSAIC_WINDOW_LAYOUT_ASSERT_SVH

// condition implies consequence in the same cycle
`define VMWL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define VMWL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/vmwl_pkg.sv
// types, codes and layout tables for the mosaic window layout block
// no dependencies; used by video_mosaic_window_layout
`timescale 1ns / 1ps

package vmwl_pkg;

   localparam int MAX_WINDOWS = 36;
   localparam int DIM_W       = 12;
   localparam int POS_W       = 13;
   localparam int IDX_W       = 6;
   localparam int CELL_W      = 3;
   localparam int CSR_IDX_W   = 3;

   // divider steps, one quotient bit each
   localparam logic [3:0] DIV_LAST_STEP = 4'd11;

   localparam logic CMD_LIST = 1'b0;
   localparam logic CMD_HIT  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CHANNELS  = 3'd4;

   localparam logic [3:0] MODE_DEFAULT = 4'd0;
   localparam logic [3:0] MODE_X1  = 4'd1;
   localparam logic [3:0] MODE_X4  = 4'd2;
   localparam logic [3:0] MODE_X6  = 4'd3;
   localparam logic [3:0] MODE_X8  = 4'd4;
   localparam logic [3:0] MODE_X9  = 4'd5;
   localparam logic [3:0] MODE_X13 = 4'd6;
   localparam logic [3:0] MODE_X16 = 4'd7;
   localparam logic [3:0] MODE_X25 = 4'd8;
   localparam logic [3:0] MODE_X36 = 4'd9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_W,
      ST_DIV_H,
      ST_LIST,
      ST_HIT_CALC,
      ST_HIT_CMP
   } state_type;

   typedef struct packed {
      logic [CELL_W-1:0] cx;
      logic [CELL_W-1:0] cy;
      logic [CELL_W-1:0] span;
   } cell_type;

   // explicit divisions map straight through, the rest follow the channel count
   function automatic logic [3:0] resolve_mode(input logic [3:0] division,
                                               input logic [6:0] channels);
      logic [3:0] mode;
      if (division >= MODE_X1 && division <= MODE_X36) begin
         mode = division;
      end else if (channels <= 7'd1) begin
         mode = MODE_X1;
      end else if (channels <= 7'd4) begin
         mode = MODE_X4;
      end else if (channels <= 7'd9) begin
         mode = MODE_X9;
      end else if (channels <= 7'd16) begin
         mode = MODE_X16;
      end else if (channels <= 7'd25) begin
         mode = MODE_X25;
      end else if (channels <= 7'd36) begin
         mode = MODE_X36;
      end else begin
         mode = MODE_X4;
      end
      return mode;
   endfunction

   function automatic logic [CELL_W-1:0] rows_of(input logic [3:0] mode);
      logic [CELL_W-1:0] rows;
      case (mode)
         MODE_X1:  rows = 3'd1;
         MODE_X4:  rows = 3'd2;
         MODE_X6:  rows = 3'd3;
         MODE_X8:  rows = 3'd4;
         MODE_X9:  rows = 3'd3;
         MODE_X13: rows = 3'd4;
         MODE_X16: rows = 3'd4;
         MODE_X25: rows = 3'd5;
         MODE_X36: rows = 3'd6;
         default:  rows = 3'd1;
      endcase
      return rows;
   endfunction

   function automatic logic [IDX_W-1:0] wins_of(input logic [3:0] mode);
      logic [IDX_W-1:0] wins;
      case (mode)
         MODE_X1:  wins = 6'd1;
         MODE_X4:  wins = 6'd4;
         MODE_X6:  wins = 6'd6;
         MODE_X8:  wins = 6'd8;
         MODE_X9:  wins = 6'd9;
         MODE_X13: wins = 6'd13;
         MODE_X16: wins = 6'd16;
         MODE_X25: wins = 6'd25;
         MODE_X36: wins = 6'd36;
         default:  wins = 6'd1;
      endcase
      return wins;
   endfunction

   // one large window top left, five small ones around it
   function automatic cell_type six_cell(input logic [3:0] idx);
      cell_type c;
      case (idx)
         4'd0:    c = '{cx: 3'd0, cy: 3'd0, span: 3'd2};
         4'd1:    c = '{cx: 3'd2, cy: 3'd0, span: 3'd1};
         4'd2:    c = '{cx: 3'd2, cy: 3'd1, span: 3'd1};
         4'd3:    c = '{cx: 3'd0, cy: 3'd2, span: 3'd1};
         4'd4:    c = '{cx: 3'd1, cy: 3'd2, span: 3'd1};
         4'd5:    c = '{cx: 3'd2, cy: 3'd2, span: 3'd1};
         default: c = '{cx: 3'd0, cy: 3'd0, span: 3'd1};
      endcase
      return c;
   endfunction

   // one large window top left, seven small ones along right and bottom
   function automatic cell_type eight_cell(input logic [3:0] idx);
      cell_type c;
      case (idx)
         4'd0:    c = '{cx: 3'd0, cy: 3'd0, span: 3'd3};
         4'd1:    c = '{cx: 3'd3, cy: 3'd0, span: 3'd1};
         4'd2:    c = '{cx: 3'd3, cy: 3'd1, span: 3'd1};
         4'd3:    c = '{cx: 3'd3, cy: 3'd2, span: 3'd1};
         4'd4:    c = '{cx: 3'd0, cy: 3'd3, span: 3'd1};
         4'd5:    c = '{cx: 3'd1, cy: 3'd3, span: 3'd1};
         4'd6:    c = '{cx: 3'd2, cy: 3'd3, span: 3'd1};
         4'd7:    c = '{cx: 3'd3, cy: 3'd3, span: 3'd1};
         default: c = '{cx: 3'd0, cy: 3'd0, span: 3'd1};
      endcase
      return c;
   endfunction

   // one large window in the center, twelve small ones on the border
   function automatic cell_type thirteen_cell(input logic [3:0] idx);
      cell_type c;
      case (idx)
         4'd0:    c = '{cx: 3'd1, cy: 3'd1, span: 3'd2};
         4'd1:    c = '{cx: 3'd0, cy: 3'd0, span: 3'd1};
         4'd2:    c = '{cx: 3'd1, cy: 3'd0, span: 3'd1};
         4'd3:    c = '{cx: 3'd2, cy: 3'd0, span: 3'd1};
         4'd4:    c = '{cx: 3'd3, cy: 3'd0, span: 3'd1};
         4'd5:    c = '{cx: 3'd0, cy: 3'd1, span: 3'd1};
         4'd6:    c = '{cx: 3'd3, cy: 3'd1, span: 3'd1};
         4'd7:    c = '{cx: 3'd0, cy: 3'd2, span: 3'd1};
         4'd8:    c = '{cx: 3'd3, cy: 3'd2, span: 3'd1};
         4'd9:    c = '{cx: 3'd0, cy: 3'd3, span: 3'd1};
         4'd10:   c = '{cx: 3'd1, cy: 3'd3, span: 3'd1};
         4'd11:   c = '{cx: 3'd2, cy: 3'd3, span: 3'd1};
         4'd12:   c = '{cx: 3'd3, cy: 3'd3, span: 3'd1};
         default: c = '{cx: 3'd0, cy: 3'd0, span: 3'd1};
      endcase
      return c;
   endfunction

endpackage

### hdl/video_mosaic_window_layout.sv
// mosaic window layout: list window rectangles or hit-test a point
// depends on vmwl_pkg and video_mosaic_window_layout_assert.svh
`timescale 1ns / 1ps
// each transaction first runs the shared divider for cell width, then for cell height;
// then a list transaction gives one result per cycle, one for each window in order;
// a hit test walks the windows through a calc and a compare state each, its single result
// on the first hit or after the last window; one transaction at a time, busy until its
// last result is out; results are strobed for one cycle and cannot be stalled
// synchronous reset: registers go to 0,0,1920,1080,1 channels, block idle

module video_mosaic_window_layout #(
   parameter int MAX_WINDOWS = vmwl_pkg::MAX_WINDOWS
) (
   input  logic                              clock,
   input  logic                              reset,
   // command
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_cmd,
   input  logic [3:0]                        req_division,
   input  logic signed [vmwl_pkg::POS_W-1:0] req_point_x,
   input  logic signed [vmwl_pkg::POS_W-1:0] req_point_y,
   // results
   output logic                              rsp_strobe,
   output logic [vmwl_pkg::IDX_W-1:0]        rsp_window_index,
   output logic                              rsp_hit,
   output logic [vmwl_pkg::POS_W-1:0]        rsp_win_x,
   output logic [vmwl_pkg::POS_W-1:0]        rsp_win_y,
   output logic [vmwl_pkg::DIM_W-1:0]        rsp_win_width,
   output logic [vmwl_pkg::DIM_W-1:0]        rsp_win_height,
   output logic                              rsp_last,
   // configuration
   input  logic                              csr_write_enable,
   input  logic [vmwl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vmwl_pkg::DIM_W-1:0]        csr_write_data
);

`include "video_mosaic_window_layout_assert.svh"

   localparam int DW = vmwl_pkg::DIM_W;
   localparam int PW = vmwl_pkg::POS_W;
   localparam int IW = vmwl_pkg::IDX_W;
   localparam int CW = vmwl_pkg::CELL_W;
   localparam int PRODW = DW + CW;

   // configuration registers
   logic [DW-1:0] screen_x_ff, screen_y_ff, screen_width_ff, screen_height_ff;
   logic [6:0]    max_channels_ff;

   // control
   vmwl_pkg::state_type state_ff, state_in;
   logic [3:0]          div_cnt_ff, div_cnt_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       col_ff, col_in, row_ff, row_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   // transaction and datapath
   logic                       cmd_ff, cmd_in;
   logic [3:0]                 mode_ff, mode_in;
   logic signed [PW-1:0]       px_ff, px_in, py_ff, py_in;
   logic [CW-1:0]              quo_rem_ff, quo_rem_in;
   logic [DW-1:0]              quo_ff, quo_in;
   logic [DW-1:0]              cw_ff, cw_in, ch_ff, ch_in;
   logic [PRODW-1:0]           rx_ff, rx_in, ry_ff, ry_in;
   logic [PRODW:0]             rx_end_ff, rx_end_in, ry_end_ff, ry_end_in;

   // result registers
   logic [IW-1:0] rsp_index_ff, rsp_index_in;
   logic          rsp_hit_ff, rsp_hit_in, rsp_last_ff, rsp_last_in;
   logic [PW-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [DW-1:0] rsp_w_ff, rsp_w_in, rsp_h_ff, rsp_h_in;

   logic                accept;
   logic [CW-1:0]       rows;
   logic [IW-1:0]       count;
   logic                last_win;
   logic [CW:0]         div_trial;
   logic                div_bit;
   logic [CW-1:0]       div_rem_next;
   logic [DW-1:0]       div_quo_next;
   logic [DW-1:0]       div_even;
   vmwl_pkg::cell_type  win_cell;
   logic [PRODW-1:0]    geo_x, geo_y, geo_w, geo_h;
   logic signed [PRODW+1:0] px_ext, py_ext;
   logic                pt_hit;

   assign accept   = start && (state_ff == vmwl_pkg::ST_IDLE);
   assign busy     = (state_ff != vmwl_pkg::ST_IDLE);
   assign rows     = vmwl_pkg::rows_of(mode_ff);
   assign count    = vmwl_pkg::wins_of(mode_ff);
   assign last_win = ((idx_ff + 6'd1) == count);

   // shared restoring divider step, one quotient bit per cycle
   assign div_trial    = {quo_rem_ff, quo_ff[DW-1]};
   assign div_bit      = (div_trial >= {1'b0, rows});
   assign div_rem_next = div_bit ? CW'(div_trial - {1'b0, rows}) : div_trial[CW-1:0];
   assign div_quo_next = {quo_ff[DW-2:0], div_bit};
   assign div_even     = {div_quo_next[DW-1:1], 1'b0};

   // cell position of the current window
   always_comb begin
      case (mode_ff)
         vmwl_pkg::MODE_X6:  win_cell = vmwl_pkg::six_cell(idx_ff[3:0]);
         vmwl_pkg::MODE_X8:  win_cell = vmwl_pkg::eight_cell(idx_ff[3:0]);
         vmwl_pkg::MODE_X13: win_cell = vmwl_pkg::thirteen_cell(idx_ff[3:0]);
         default:            win_cell = '{cx: col_ff, cy: row_ff, span: 3'd1};
      endcase
   end

   // window geometry unit, shared by list and hit test
   assign geo_x = PRODW'(screen_x_ff) + cw_ff * win_cell.cx;
   assign geo_y = PRODW'(screen_y_ff) + ch_ff * win_cell.cy;
   assign geo_w = cw_ff * win_cell.span;
   assign geo_h = ch_ff * win_cell.span;

   // half-open containment test on the registered rectangle
   assign px_ext = (PRODW + 2)'(px_ff);
   assign py_ext = (PRODW + 2)'(py_ff);
   assign pt_hit = (px_ext >= $signed({2'b00, rx_ff})) &&
                   (px_ext <  $signed({1'b0, rx_end_ff})) &&
                   (py_ext >= $signed({2'b00, ry_ff})) &&
                   (py_ext <  $signed({1'b0, ry_end_ff}));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vmwl_pkg::ST_IDLE: begin
            if (start) state_in = vmwl_pkg::ST_DIV_W;
         end
         vmwl_pkg::ST_DIV_W: begin
            if (div_cnt_ff == vmwl_pkg::DIV_LAST_STEP) state_in = vmwl_pkg::ST_DIV_H;
         end
         vmwl_pkg::ST_DIV_H: begin
            if (div_cnt_ff == vmwl_pkg::DIV_LAST_STEP) begin
               state_in = (cmd_ff == vmwl_pkg::CMD_LIST) ? vmwl_pkg::ST_LIST
                                                         : vmwl_pkg::ST_HIT_CALC;
            end
         end
         vmwl_pkg::ST_LIST: begin
            if (last_win) state_in = vmwl_pkg::ST_IDLE;
         end
         vmwl_pkg::ST_HIT_CALC: begin
            state_in = vmwl_pkg::ST_HIT_CMP;
         end
         vmwl_pkg::ST_HIT_CMP: begin
            if (pt_hit || last_win) state_in = vmwl_pkg::ST_IDLE;
            else                    state_in = vmwl_pkg::ST_HIT_CALC;
         end
         default: state_in = vmwl_pkg::ST_IDLE;
      endcase
   end

   // datapath and result controls
   always_comb begin
      cmd_in        = cmd_ff;
      mode_in       = mode_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      div_cnt_in    = div_cnt_ff;
      quo_rem_in    = quo_rem_ff;
      quo_in        = quo_ff;
      cw_in         = cw_ff;
      ch_in         = ch_ff;
      idx_in        = idx_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      rx_end_in     = rx_end_ff;
      ry_end_in     = ry_end_ff;
      rsp_strobe_in = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_h_in      = rsp_h_ff;
      case (state_ff)
         vmwl_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in     = req_cmd;
               mode_in    = vmwl_pkg::resolve_mode(req_division, max_channels_ff);
               px_in      = req_point_x;
               py_in      = req_point_y;
               div_cnt_in = '0;
               quo_rem_in = '0;
               quo_in     = screen_width_ff;
            end
         end
         vmwl_pkg::ST_DIV_W: begin
            div_cnt_in = div_cnt_ff + 4'd1;
            quo_rem_in = div_rem_next;
            quo_in     = div_quo_next;
            if (div_cnt_ff == vmwl_pkg::DIV_LAST_STEP) begin
               cw_in      = div_even;
               div_cnt_in = '0;
               quo_rem_in = '0;
               quo_in     = screen_height_ff;
            end
         end
         vmwl_pkg::ST_DIV_H: begin
            div_cnt_in = div_cnt_ff + 4'd1;
            quo_rem_in = div_rem_next;
            quo_in     = div_quo_next;
            if (div_cnt_ff == vmwl_pkg::DIV_LAST_STEP) begin
               ch_in  = div_even;
               idx_in = '0;
               col_in = '0;
               row_in = '0;
            end
         end
         vmwl_pkg::ST_LIST: begin
            rsp_strobe_in = 1'b1;
            rsp_index_in  = idx_ff;
            rsp_hit_in    = 1'b1;
            rsp_last_in   = last_win;
            rsp_x_in      = geo_x[PW-1:0];
            rsp_y_in      = geo_y[PW-1:0];
            rsp_w_in      = geo_w[DW-1:0];
            rsp_h_in      = geo_h[DW-1:0];
         end
         vmwl_pkg::ST_HIT_CALC: begin
            rx_in     = geo_x;
            ry_in     = geo_y;
            rx_end_in = {1'b0, geo_x} + {1'b0, geo_w};
            ry_end_in = {1'b0, geo_y} + {1'b0, geo_h};
         end
         vmwl_pkg::ST_HIT_CMP: begin
            if (pt_hit || last_win) begin
               rsp_strobe_in = 1'b1;
               rsp_index_in  = pt_hit ? idx_ff : count;
               rsp_hit_in    = pt_hit;
               rsp_last_in   = 1'b1;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               rsp_w_in      = '0;
               rsp_h_in      = '0;
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
      // window walk, column and row for the plain grid modes
      if (state_ff == vmwl_pkg::ST_LIST ||
          (state_ff == vmwl_pkg::ST_HIT_CMP && !pt_hit && !last_win)) begin
         idx_in = idx_ff + 6'd1;
         if ((col_ff + 3'd1) == rows) begin
            col_in = '0;
            row_in = row_ff + 3'd1;
         end else begin
            col_in = col_ff + 3'd1;
         end
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= vmwl_pkg::ST_IDLE;
         rsp_strobe_ff    <= 1'b0;
         screen_x_ff      <= '0;
         screen_y_ff      <= '0;
         screen_width_ff  <= 12'd1920;
         screen_height_ff <= 12'd1080;
         max_channels_ff  <= 7'd1;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            case (csr_index)
               vmwl_pkg::CSR_SCREEN_X:      screen_x_ff      <= csr_write_data;
               vmwl_pkg::CSR_SCREEN_Y:      screen_y_ff      <= csr_write_data;
               vmwl_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_write_data;
               vmwl_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_write_data;
               vmwl_pkg::CSR_MAX_CHANNELS:  max_channels_ff  <= csr_write_data[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      mode_ff      <= mode_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      div_cnt_ff   <= div_cnt_in;
      quo_rem_ff   <= quo_rem_in;
      quo_ff       <= quo_in;
      cw_ff        <= cw_in;
      ch_ff        <= ch_in;
      idx_ff       <= idx_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      rx_end_ff    <= rx_end_in;
      ry_end_ff    <= ry_end_in;
      rsp_index_ff <= rsp_index_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_w_ff     <= rsp_w_in;
      rsp_h_ff     <= rsp_h_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_window_index = rsp_index_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_win_x        = rsp_x_ff;
   assign rsp_win_y        = rsp_y_ff;
   assign rsp_win_width    = rsp_w_ff;
   assign rsp_win_height   = rsp_h_ff;

   // checks
   `VMWL_ASSERT_NEXT(a_no_result_after_accept, clock, reset, accept, !rsp_strobe_ff, "result right after accept")
   `VMWL_ASSERT_NOW(a_miss_is_last, clock, reset, rsp_strobe_ff && !rsp_hit_ff, rsp_last_ff, "miss result not marked last")
   `VMWL_ASSERT_NEXT(a_list_in_order, clock, reset, rsp_strobe_ff && !rsp_last_ff, rsp_strobe_ff && (rsp_index_ff == ($past(rsp_index_ff) + 6'd1)), "list results not consecutive")
   `VMWL_ASSERT_NOW(a_index_in_range, clock, reset, rsp_strobe_ff, {26'd0, rsp_index_ff} <= MAX_WINDOWS, "window index out of range")

endmodule

### tb/vmwl_layout_checker.sv
// scoreboard for the mosaic window layout block: predicts window rectangles and hit tests
// depends on vmwl_pkg; instantiated beside the block by tb_video_mosaic_window_layout
`timescale 1ns / 1ps

module vmwl_layout_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic                              req_cmd,
   input  logic [3:0]                        req_division,
   input  logic signed [vmwl_pkg::POS_W-1:0] req_point_x,
   input  logic signed [vmwl_pkg::POS_W-1:0] req_point_y,
   input  logic                              rsp_strobe,
   input  logic [vmwl_pkg::IDX_W-1:0]        rsp_window_index,
   input  logic                              rsp_hit,
   input  logic [vmwl_pkg::POS_W-1:0]        rsp_win_x,
   input  logic [vmwl_pkg::POS_W-1:0]        rsp_win_y,
   input  logic [vmwl_pkg::DIM_W-1:0]        rsp_win_width,
   input  logic [vmwl_pkg::DIM_W-1:0]        rsp_win_height,
   input  logic                              rsp_last,
   input  logic                              csr_write_enable,
   input  logic [vmwl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vmwl_pkg::DIM_W-1:0]        csr_write_data,
   input  logic                              end_check,
   output int                                failure_count,
   output int                                pending
);
   import vmwl_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] window_index;
      logic             hit;
      logic [POS_W-1:0] win_x;
      logic [POS_W-1:0] win_y;
      logic [DIM_W-1:0] win_width;
      logic [DIM_W-1:0] win_height;
      logic             last;
   } window_result_t;

   typedef struct packed {
      logic [2:0] col;
      logic [2:0] row;
      logic [2:0] span;
   } cell_pos_t;

   window_result_t expected_windows[$];

   // local copy of the layout registers
   logic [DIM_W-1:0] cfg_x;
   logic [DIM_W-1:0] cfg_y;
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   logic [6:0]       cfg_channels;
   bit               closed;

   initial begin
      failure_count = 0;
      pending       = 0;
      closed        = 0;
   end

   // explicit divisions pass through, else the smallest square grid that fits, X4 over 36
   function automatic logic [3:0] effective_mode(input logic [3:0] division,
                                                 input logic [6:0] channels);
      int side;
      if (division >= MODE_X1 && division <= MODE_X36) return division;
      side = 1;
      while (side <= 6 && int'(channels) > side * side) side++;
      case (side)
         1:       return MODE_X1;
         2:       return MODE_X4;
         3:       return MODE_X9;
         4:       return MODE_X16;
         5:       return MODE_X25;
         6:       return MODE_X36;
         default: return MODE_X4;
      endcase
   endfunction

   function automatic int grid_rows(input logic [3:0] mode);
      case (mode)
         MODE_X4:  return 2;
         MODE_X6:  return 3;
         MODE_X8:  return 4;
         MODE_X9:  return 3;
         MODE_X13: return 4;
         MODE_X16: return 4;
         MODE_X25: return 5;
         MODE_X36: return 6;
         default:  return 1;
      endcase
   endfunction

   function automatic int window_count(input logic [3:0] mode);
      case (mode)
         MODE_X4:  return 4;
         MODE_X6:  return 6;
         MODE_X8:  return 8;
         MODE_X9:  return 9;
         MODE_X13: return 13;
         MODE_X16: return 16;
         MODE_X25: return 25;
         MODE_X36: return 36;
         default:  return 1;
      endcase
   endfunction

   // cell column, row and span of one window; uneven layouts have one big window
   function automatic cell_pos_t place_window(input logic [3:0] mode, input int idx);
      cell_pos_t p;
      p = '{col: 3'(idx % grid_rows(mode)), row: 3'(idx / grid_rows(mode)), span: 3'd1};
      case (mode)
         MODE_X6: begin
            case (idx)
               0: p = '{col: 3'd0, row: 3'd0, span: 3'd2};
               1: p = '{col: 3'd2, row: 3'd0, span: 3'd1};
               2: p = '{col: 3'd2, row: 3'd1, span: 3'd1};
               3: p = '{col: 3'd0, row: 3'd2, span: 3'd1};
               4: p = '{col: 3'd1, row: 3'd2, span: 3'd1};
               default: p = '{col: 3'd2, row: 3'd2, span: 3'd1};
            endcase
         end
         MODE_X8: begin
            if (idx == 0) p = '{col: 3'd0, row: 3'd0, span: 3'd3};
            else if (idx <= 3) p = '{col: 3'd3, row: 3'(idx - 1), span: 3'd1};
            else p = '{col: 3'(idx - 4), row: 3'd3, span: 3'd1};
         end
         MODE_X13: begin
            case (idx)
               0: p = '{col: 3'd1, row: 3'd1, span: 3'd2};
               1, 2, 3, 4: p = '{col: 3'(idx - 1), row: 3'd0, span: 3'd1};
               5: p = '{col: 3'd0, row: 3'd1, span: 3'd1};
               6: p = '{col: 3'd3, row: 3'd1, span: 3'd1};
               7: p = '{col: 3'd0, row: 3'd2, span: 3'd1};
               8: p = '{col: 3'd3, row: 3'd2, span: 3'd1};
               default: p = '{col: 3'(idx - 9), row: 3'd3, span: 3'd1};
            endcase
         end
         default: ;
      endcase
      return p;
   endfunction

   // expected results of one accepted transaction
   function automatic void predict_layout(input logic cmd, input logic [3:0] division,
                                          input logic signed [POS_W-1:0] point_x,
                                          input logic signed [POS_W-1:0] point_y);
      logic [3:0]     mode;
      int             rows, count, cell_w, cell_h, px, py, wx, wy, ww, wh, found;
      cell_pos_t      p;
      window_result_t r;
      mode   = effective_mode(division, cfg_channels);
      rows   = grid_rows(mode);
      count  = window_count(mode);
      cell_w = 2 * ((int'(cfg_width) / rows) / 2);
      cell_h = 2 * ((int'(cfg_height) / rows) / 2);
      px     = point_x;
      py     = point_y;
      found  = count;
      for (int i = 0; i < count; i++) begin
         p  = place_window(mode, i);
         wx = int'(cfg_x) + cell_w * int'(p.col);
         wy = int'(cfg_y) + cell_h * int'(p.row);
         ww = cell_w * int'(p.span);
         wh = cell_h * int'(p.span);
         if (cmd == CMD_LIST) begin
            r.window_index = i[IDX_W-1:0];
            r.hit          = 1'b1;
            r.win_x        = wx[POS_W-1:0];
            r.win_y        = wy[POS_W-1:0];
            r.win_width    = ww[DIM_W-1:0];
            r.win_height   = wh[DIM_W-1:0];
            r.last         = (i == count - 1);
            expected_windows.push_back(r);
         end else if (found == count && px >= wx && px < wx + ww &&
                      py >= wy && py < wy + wh) begin
            found = i;
         end
      end
      // hit test: first containing window, or the window count on a miss
      if (cmd == CMD_HIT) begin
         r              = '0;
         r.window_index = found[IDX_W-1:0];
         r.hit          = (found < count);
         r.last         = 1'b1;
         expected_windows.push_back(r);
      end
   endfunction

   function automatic void report_failure(input string what, input window_result_t exp,
                                          input window_result_t got);
      failure_count++;
      if (failure_count <= 10)
         $display("%0t: %s: exp idx %0d hit %0d x %0d y %0d w %0d h %0d last %0d, got idx %0d hit %0d x %0d y %0d w %0d h %0d last %0d",
                  $time, what, exp.window_index, exp.hit, exp.win_x, exp.win_y,
                  exp.win_width, exp.win_height, exp.last, got.window_index, got.hit,
                  got.win_x, got.win_y, got.win_width, got.win_height, got.last);
   endfunction

   always @(posedge clock) begin
      window_result_t got;
      window_result_t exp;
      got = '{window_index: rsp_window_index, hit: rsp_hit, win_x: rsp_win_x,
              win_y: rsp_win_y, win_width: rsp_win_width, win_height: rsp_win_height,
              last: rsp_last};
      if (reset) begin
         cfg_x        = '0;
         cfg_y        = '0;
         cfg_width    = 12'd1920;
         cfg_height   = 12'd1080;
         cfg_channels = 7'd1;
         expected_windows.delete();
      end else begin
         // compare a strobed result against the oldest expectation
         if (rsp_strobe) begin
            if (expected_windows.size() == 0) begin
               report_failure("unexpected result", '0, got);
            end else begin
               exp = expected_windows.pop_front();
               if (exp !== got) report_failure("result mismatch", exp, got);
            end
         end
         // accepted transaction sees the registers as they were before this edge
         if (start && !busy) predict_layout(req_cmd, req_division, req_point_x, req_point_y);
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SCREEN_X:      cfg_x        = csr_write_data;
               CSR_SCREEN_Y:      cfg_y        = csr_write_data;
               CSR_SCREEN_WIDTH:  cfg_width    = csr_write_data;
               CSR_SCREEN_HEIGHT: cfg_height   = csr_write_data;
               CSR_MAX_CHANNELS:  cfg_channels = csr_write_data[6:0];
               default: ;
            endcase
         end
         // leftovers at the end of the run
         if (end_check && !closed) begin
            closed = 1;
            if (expected_windows.size() != 0) begin
               $display("%0t: %0d expected results never arrived", $time,
                        expected_windows.size());
               failure_count += expected_windows.size();
            end
         end
      end
      pending = expected_windows.size();
   end

endmodule

### tb/tb_video_mosaic_window_layout.sv
// top of the mosaic window layout testbench: clock, reset, stimulus and verdict
// depends on vmwl_pkg, video_mosaic_window_layout and vmwl_layout_checker
`timescale 1ns / 1ps

module tb_video_mosaic_window_layout;
   import vmwl_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 120;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 35;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       start            = 1'b0;
   logic                       busy;
   logic                       req_cmd          = CMD_LIST;
   logic [3:0]                 req_division     = MODE_DEFAULT;
   logic signed [POS_W-1:0]    req_point_x      = '0;
   logic signed [POS_W-1:0]    req_point_y      = '0;
   logic                       rsp_strobe;
   logic [IDX_W-1:0]           rsp_window_index;
   logic                       rsp_hit;
   logic [POS_W-1:0]           rsp_win_x;
   logic [POS_W-1:0]           rsp_win_y;
   logic [DIM_W-1:0]           rsp_win_width;
   logic [DIM_W-1:0]           rsp_win_height;
   logic                       rsp_last;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index        = CSR_SCREEN_X;
   logic [DIM_W-1:0]           csr_write_data   = '0;
   logic                       end_check        = 1'b0;
   int                         failure_count;
   int                         pending;
   int                         cycle_count      = 0;
   int                         idle_pct         = 0;
   // current screen rectangle, used to aim hit-test points
   int                         scr_x            = 0;
   int                         scr_y            = 0;
   int                         scr_w            = 1920;
   int                         scr_h            = 1080;

   always #5 clock = ~clock;

   video_mosaic_window_layout dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_division     (req_division),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_strobe       (rsp_strobe),
      .rsp_window_index (rsp_window_index),
      .rsp_hit          (rsp_hit),
      .rsp_win_x        (rsp_win_x),
      .rsp_win_y        (rsp_win_y),
      .rsp_win_width    (rsp_win_width),
      .rsp_win_height   (rsp_win_height),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   vmwl_layout_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_division     (req_division),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_strobe       (rsp_strobe),
      .rsp_window_index (rsp_window_index),
      .rsp_hit          (rsp_hit),
      .rsp_win_x        (rsp_win_x),
      .rsp_win_y        (rsp_win_y),
      .rsp_win_width    (rsp_win_width),
      .rsp_win_height   (rsp_win_height),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .end_check        (end_check),
      .failure_count    (failure_count),
      .pending          (pending)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one transaction; called and returning at a falling edge, start left high
   task automatic send_request(input logic cmd, input logic [3:0] division,
                               input logic signed [POS_W-1:0] px,
                               input logic signed [POS_W-1:0] py);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start        <= 1'b1;
      req_cmd      <= cmd;
      req_division <= division;
      req_point_x  <= px;
      req_point_y  <= py;
      // busy only moves at rising edges, so its value now holds for the next one
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   // let every expected result arrive and the block go idle
   task automatic wait_idle();
      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // write all layout registers while the block is idle
   task automatic set_layout(input int x, input int y, input int w, input int h,
                             input logic [DIM_W-1:0] channels_word);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SCREEN_X;      csr_write_data <= x[DIM_W-1:0];  @(negedge clock);
      csr_index <= CSR_SCREEN_Y;      csr_write_data <= y[DIM_W-1:0];  @(negedge clock);
      csr_index <= CSR_SCREEN_WIDTH;  csr_write_data <= w[DIM_W-1:0];  @(negedge clock);
      csr_index <= CSR_SCREEN_HEIGHT; csr_write_data <= h[DIM_W-1:0];  @(negedge clock);
      csr_index <= CSR_MAX_CHANNELS;  csr_write_data <= channels_word; @(negedge clock);
      csr_write_enable <= 1'b0;
      scr_x = x;
      scr_y = y;
      scr_w = w;
      scr_h = h;
   endtask

   function automatic int pick_dim(input int typical_max);
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 4095;
         2:       return $urandom_range(0, 15);
         default: return $urandom_range(0, typical_max);
      endcase
   endfunction

   // channel counts around each grid threshold, upper data bits random
   function automatic logic [DIM_W-1:0] pick_channels();
      logic [6:0] ch;
      case ($urandom_range(0, 15))
         0:  ch = 7'd0;
         1:  ch = 7'd1;
         2:  ch = 7'd4;
         3:  ch = 7'd5;
         4:  ch = 7'd9;
         5:  ch = 7'd10;
         6:  ch = 7'd16;
         7:  ch = 7'd17;
         8:  ch = 7'd25;
         9:  ch = 7'd26;
         10: ch = 7'd36;
         11: ch = 7'd37;
         12: ch = 7'd64;
         13: ch = 7'd127;
         default: ch = 7'($urandom_range(0, 127));
      endcase
      return {5'($urandom), ch};
   endfunction

   // mostly inside or just around the screen, sometimes on a cell edge, some noise
   function automatic logic signed [POS_W-1:0] pick_coord(input int origin, input int extent);
      int v;
      int rows_guess;
      int cell_span;
      rows_guess = $urandom_range(1, 6);
      cell_span  = 2 * ((extent / rows_guess) / 2);
      case ($urandom_range(0, 9))
         0, 1:    v = $urandom;
         2, 3:    v = origin + cell_span * $urandom_range(0, rows_guess) - $urandom_range(0, 1);
         default: v = origin - 2 + $urandom_range(0, extent + 4);
      endcase
      return v[POS_W-1:0];
   endfunction

   function automatic logic [3:0] pick_division();
      if ($urandom_range(0, 3) == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(MODE_X1, MODE_X36));
   endfunction

   initial begin
      logic [3:0] d;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every division listed at the reset layout
      for (d = MODE_X1; d <= MODE_X36; d++) send_request(CMD_LIST, d, '0, '0);
      send_request(CMD_LIST, MODE_DEFAULT, '0, '0);
      send_request(CMD_LIST, 4'hF, 13'sd100, -13'sd100);
      // hit tests on the screen edges, the extremes of the point range and a few layouts
      send_request(CMD_HIT, MODE_X1, 13'sd0, 13'sd0);
      send_request(CMD_HIT, MODE_X1, -13'sd1, 13'sd0);
      send_request(CMD_HIT, MODE_X1, 13'sd1919, 13'sd1079);
      send_request(CMD_HIT, MODE_X1, 13'sd1920, 13'sd0);
      send_request(CMD_HIT, MODE_X1, -13'sd4096, -13'sd4096);
      send_request(CMD_HIT, MODE_X1, 13'sd4095, 13'sd4095);
      send_request(CMD_HIT, MODE_X13, 13'sd960, 13'sd540);
      send_request(CMD_HIT, MODE_X36, 13'sd1919, 13'sd1079);
      send_request(CMD_HIT, MODE_X6, 13'sd1300, 13'sd700);
      send_request(CMD_HIT, MODE_X8, 13'sd1440, 13'sd500);

      // largest screen far from the origin, default picks the 36 grid
      set_layout(4095, 4095, 4095, 4095, 12'd36);
      send_request(CMD_LIST, MODE_DEFAULT, '0, '0);
      send_request(CMD_HIT, MODE_DEFAULT, 13'sd4095, 13'sd4095);
      // empty screen: windows of zero size contain nothing, no channels gives one window
      set_layout(0, 0, 0, 0, 12'd0);
      send_request(CMD_LIST, MODE_DEFAULT, '0, '0);
      send_request(CMD_HIT, MODE_X1, 13'sd0, 13'sd0);
      // more channels than the largest grid falls back to four windows
      set_layout(0, 0, 1920, 1080, 12'd64);
      send_request(CMD_LIST, MODE_DEFAULT, '0, '0);

      // random phases, each with its own layout, sender pacing cycles through all three
      for (int ph = 0; ph < PHASES; ph++) begin
         set_layout(pick_dim(2047), pick_dim(2047), pick_dim(4095), pick_dim(4095),
                    pick_channels());
         case (ph % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 78;
            default: idle_pct = 36;
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) < 3)
               send_request(CMD_LIST, pick_division(), POS_W'($urandom), POS_W'($urandom));
            else
               send_request(CMD_HIT, pick_division(), pick_coord(scr_x, scr_w),
                            pick_coord(scr_y, scr_h));
         end
      end

      // drain and verdict
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      end_check <= 1'b1;
      repeat (2) @(negedge clock);
      if (failure_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
